>>> hdl/mf33_pkg.sv
// ----------------------------------------------------------------------------
// mf33_pkg: shared types and constants of the 3x3 RGB median filter
// Field widths, register codes and reset values, the per-item descriptor
// that travels down the pipeline, and the stage-advance bundle for the lanes.
// ----------------------------------------------------------------------------
package mf33_pkg;

   localparam int PIX_W   = 8;
   localparam int RGB_W   = 3 * PIX_W;
   localparam int COORD_W = 12;
   localparam int CFG_W   = 13;
   localparam int LINE_W  = 2 * RGB_W;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

   // register select, taken from paddr[2]
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic               has_med;
      logic               border;
      logic [COORD_W-1:0] med_col;
      logic [COORD_W-1:0] med_row;
      logic [COORD_W-1:0] pix_col;
      logic [COORD_W-1:0] pix_row;
      logic [RGB_W-1:0]   pix;
   } item_info_type;

   typedef struct packed {
      logic s1_adv;
      logic s2_adv;
   } pipe_ctl_type;

endpackage

>>> hdl/mf33_line_buf.sv
// ----------------------------------------------------------------------------
// mf33_line_buf: line store for the two rows above the current pixel
// One word per column holds {row above, row two above}. One write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module mf33_line_buf #(
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [mf33_pkg::LINE_W-1:0] rd_data,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [mf33_pkg::LINE_W-1:0] wr_data
);

   logic [mf33_pkg::LINE_W-1:0] mem [DEPTH];
   logic [mf33_pkg::LINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/mf33_lane.sv
// ----------------------------------------------------------------------------
// mf33_lane: median datapath for one color channel
// Sorts each incoming column once, keeps the last three sorted columns as
// the window, then takes max of lows, median of mids and min of highs, and
// the median of those three.
// ----------------------------------------------------------------------------
module mf33_lane (
   input  logic                          clock,
   input  mf33_pkg::pipe_ctl_type        ctl,
   input  logic [mf33_pkg::PIX_W-1:0]    col_top,
   input  logic [mf33_pkg::PIX_W-1:0]    col_mid,
   input  logic [mf33_pkg::PIX_W-1:0]    col_bot,
   output logic [mf33_pkg::PIX_W-1:0]    median
);

   typedef logic [mf33_pkg::PIX_W-1:0] pix_type;

   typedef struct packed {
      pix_type lo;
      pix_type md;
      pix_type hi;
   } sorted_col_type;

   function automatic pix_type min3(pix_type a, pix_type b, pix_type c);
      pix_type m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic pix_type max3(pix_type a, pix_type b, pix_type c);
      pix_type m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic pix_type med3(pix_type a, pix_type b, pix_type c);
      pix_type lo;
      pix_type hi;
      pix_type t;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      t  = (hi < c) ? hi : c;
      return (lo > t) ? lo : t;
   endfunction

   sorted_col_type new_col;
   sorted_col_type win_ff [3];
   pix_type        lo_max_in, md_med_in, hi_min_in;
   pix_type        lo_max_ff, md_med_ff, hi_min_ff;

   always_comb begin
      new_col.lo = min3(col_top, col_mid, col_bot);
      new_col.md = med3(col_top, col_mid, col_bot);
      new_col.hi = max3(col_top, col_mid, col_bot);
   end

   // window: oldest column in slot 0, current column in slot 2
   always_ff @(posedge clock) begin
      if (ctl.s1_adv) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= new_col;
      end
   end

   always_comb begin
      lo_max_in = max3(win_ff[0].lo, win_ff[1].lo, win_ff[2].lo);
      md_med_in = med3(win_ff[0].md, win_ff[1].md, win_ff[2].md);
      hi_min_in = min3(win_ff[0].hi, win_ff[1].hi, win_ff[2].hi);
   end

   always_ff @(posedge clock) begin
      if (ctl.s2_adv) begin
         lo_max_ff <= lo_max_in;
         md_med_ff <= md_med_in;
         hi_min_ff <= hi_min_in;
      end
   end

   assign median = med3(lo_max_ff, md_med_ff, hi_min_ff);

endmodule

>>> hdl/mf33_merge.sv
// ----------------------------------------------------------------------------
// mf33_merge: result stage
// Joins the three lane medians with the item descriptor and hands out up to
// two results per item (median of the upper-left neighbor, then the border
// copy) through the output register.
// ----------------------------------------------------------------------------
module mf33_merge (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  mf33_pkg::item_info_type          in_info,
   input  logic [mf33_pkg::RGB_W-1:0]       med_rgb,
   output logic                             take,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mf33_pkg::COORD_W-1:0]     rsp_out_col,
   output logic [mf33_pkg::COORD_W-1:0]     rsp_out_row,
   output logic [mf33_pkg::PIX_W-1:0]       rsp_out_red,
   output logic [mf33_pkg::PIX_W-1:0]       rsp_out_green,
   output logic [mf33_pkg::PIX_W-1:0]       rsp_out_blue,
   output logic                             rsp_out_last
);

   localparam int PW = mf33_pkg::PIX_W;

   mf33_pkg::item_info_type     s3_info_ff;
   logic                        s3_valid_ff;
   logic                        s3_med_pend_ff, s3_med_pend_in;
   logic                        s3_done;
   logic                        load;
   logic                        out_free;

   logic                        emit_valid;
   logic [mf33_pkg::COORD_W-1:0] emit_col, emit_row;
   logic [mf33_pkg::RGB_W-1:0]   emit_rgb;
   logic                        emit_last;

   logic                        rsp_valid_ff;
   logic [mf33_pkg::COORD_W-1:0] rsp_col_ff, rsp_row_ff;
   logic [mf33_pkg::RGB_W-1:0]   rsp_rgb_ff;
   logic                        rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      emit_valid     = 1'b0;
      emit_col       = s3_info_ff.pix_col;
      emit_row       = s3_info_ff.pix_row;
      emit_rgb       = s3_info_ff.pix;
      emit_last      = 1'b1;
      s3_done        = 1'b0;
      s3_med_pend_in = s3_med_pend_ff;
      if (s3_valid_ff) begin
         if (s3_med_pend_ff) begin
            emit_valid = 1'b1;
            emit_col   = s3_info_ff.med_col;
            emit_row   = s3_info_ff.med_row;
            emit_rgb   = med_rgb;
            emit_last  = !s3_info_ff.border;
            if (out_free) begin
               s3_med_pend_in = 1'b0;
            end
            // hold the item for its border copy
            s3_done = out_free && !s3_info_ff.border;
         end else if (s3_info_ff.border) begin
            emit_valid = 1'b1;
            s3_done    = out_free;
         end else begin
            s3_done = 1'b1;
         end
      end
   end

   assign take = !s3_valid_ff || s3_done;
   assign load = in_valid && take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff    <= 1'b0;
         s3_med_pend_ff <= 1'b0;
      end else if (load) begin
         s3_valid_ff    <= 1'b1;
         s3_med_pend_ff <= in_info.has_med;
      end else if (s3_done) begin
         s3_valid_ff    <= 1'b0;
         s3_med_pend_ff <= 1'b0;
      end else begin
         s3_med_pend_ff <= s3_med_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s3_info_ff <= in_info;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit_valid) begin
         rsp_col_ff  <= emit_col;
         rsp_row_ff  <= emit_row;
         rsp_rgb_ff  <= emit_rgb;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_red   = rsp_rgb_ff[2*PW +: PW];
   assign rsp_out_green = rsp_rgb_ff[PW +: PW];
   assign rsp_out_blue  = rsp_rgb_ff[0 +: PW];
   assign rsp_out_last  = rsp_last_ff;

   // an item with both results must stay for its border copy
   a_border_after_median: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && s3_med_pend_ff && s3_info_ff.border && out_free
      |=> s3_valid_ff && !s3_med_pend_ff)
      else $error("item left before its border copy was sent");

endmodule

>>> hdl/median_3x3_rgb_filter.sv
// ----------------------------------------------------------------------------
// median_3x3_rgb_filter: streaming 3x3 median filter for RGB pixels
// Pixels enter in raster order on the req_ channel (valid/ready); results
// leave on the rsp_ channel with their column and row. Interior pixels get
// the per-channel median of their 3x3 neighborhood, border pixels pass
// unchanged. An interior pixel is sent when the pixel below-right of it is
// transferred; a border pixel when it is transferred itself, after any median
// that the same pixel completes (rsp_out_last marks the final one).
// Path: a result reaches rsp_ through the line-store read, issued at the transfer
// that causes it, then the column sort, the column merge and the output
// register. A second result follows once the output register has room.
// Throughput: one pixel per clock while results are taken; a pixel that causes
// two results holds the result stage until both pass the single output register.
// The user writes frame_width (0x0) and frame_height (0x4) over APB only while
// the block is idle (not enforced); any write restarts the frame at column 0, row 0.
// Reset clears the pipeline and counters and loads 640x480; the line store
// keeps no reset state and needs no clearing pass. When rsp_ready is low the
// result holds and the pipeline keeps taking pixels until its stages fill.
// ----------------------------------------------------------------------------
module median_3x3_rgb_filter #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mf33_pkg::PIX_W-1:0]    req_red,
   input  logic [mf33_pkg::PIX_W-1:0]    req_green,
   input  logic [mf33_pkg::PIX_W-1:0]    req_blue,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mf33_pkg::COORD_W-1:0]  rsp_out_col,
   output logic [mf33_pkg::COORD_W-1:0]  rsp_out_row,
   output logic [mf33_pkg::PIX_W-1:0]    rsp_out_red,
   output logic [mf33_pkg::PIX_W-1:0]    rsp_out_green,
   output logic [mf33_pkg::PIX_W-1:0]    rsp_out_blue,
   output logic                          rsp_out_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int CWC = CW + 1;
   localparam int RWC = RW + 1;
   localparam int PW  = mf33_pkg::PIX_W;
   localparam int RGBW = mf33_pkg::RGB_W;
   localparam int CFGW = mf33_pkg::CFG_W;
   localparam int CDW  = mf33_pkg::COORD_W;

   // ---------------- configuration ----------------
   logic [CFGW-1:0] frame_width_ff, frame_height_ff;
   logic            cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= mf33_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= mf33_pkg::FRAME_HEIGHT_RST;
      end else if (cfg_wr) begin
         if (paddr[2] == mf33_pkg::REG_FRAME_HEIGHT) begin
            frame_height_ff <= pwdata[CFGW-1:0];
         end else begin
            frame_width_ff <= pwdata[CFGW-1:0];
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == mf33_pkg::REG_FRAME_HEIGHT) begin
         prdata[CFGW-1:0] = frame_height_ff;
      end else begin
         prdata[CFGW-1:0] = frame_width_ff;
      end
   end

   // clamp the sizes to 1..MAX
   logic [CWC-1:0] eff_w;
   logic [RWC-1:0] eff_h;

   always_comb begin
      if (frame_width_ff == '0) begin
         eff_w = CWC'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = CWC'(MAX_WIDTH);
      end else begin
         eff_w = CWC'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         eff_h = RWC'(1);
      end else if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = RWC'(MAX_HEIGHT);
      end else begin
         eff_h = RWC'(frame_height_ff);
      end
   end

   // ---------------- pipeline control ----------------
   logic                    accept;
   logic                    s1_valid_ff, s2_valid_ff;
   logic                    s1_adv, s2_adv;
   logic                    merge_take;
   mf33_pkg::pipe_ctl_type  ctl;

   assign s2_adv    = s2_valid_ff && merge_take;
   assign s1_adv    = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   assign ctl.s1_adv = s1_adv;
   assign ctl.s2_adv = s2_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_adv) begin
            s2_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- position counters ----------------
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          col_last, row_last;

   assign col_last = (CWC'(col_ff) + CWC'(1)) >= eff_w;
   assign row_last = (RWC'(row_ff) + RWC'(1)) >= eff_h;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_wr) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- item descriptor ----------------
   mf33_pkg::item_info_type acc_info, s1_info_ff, s2_info_ff;
   logic [CW-1:0]           s1_col_ff;

   always_comb begin
      acc_info.has_med = (col_ff >= CW'(2)) && (row_ff >= RW'(2));
      acc_info.border  = (col_ff == '0) || (row_ff == '0) || col_last || row_last;
      acc_info.med_col = CDW'(col_ff - CW'(1));
      acc_info.med_row = CDW'(row_ff - RW'(1));
      acc_info.pix_col = CDW'(col_ff);
      acc_info.pix_row = CDW'(row_ff);
      acc_info.pix     = {req_red, req_green, req_blue};
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= acc_info;
         s1_col_ff  <= col_ff;
      end
      if (s1_adv) begin
         s2_info_ff <= s1_info_ff;
      end
   end

   // ---------------- line store ----------------
   logic [mf33_pkg::LINE_W-1:0] line_rd;
   logic [RGBW-1:0]             above1, above2;

   // word layout: {row above, row two above}
   assign above1 = line_rd[RGBW +: RGBW];
   assign above2 = line_rd[0 +: RGBW];

   mf33_line_buf #(
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (line_rd),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_info_ff.pix, above1})
   );

   // ---------------- channel lanes ----------------
   logic [RGBW-1:0] med_rgb;

   for (genvar k = 0; k < 3; k++) begin : g_lane
      mf33_lane u_lane (
         .clock   (clock),
         .ctl     (ctl),
         .col_top (above2[(2-k)*PW +: PW]),
         .col_mid (above1[(2-k)*PW +: PW]),
         .col_bot (s1_info_ff.pix[(2-k)*PW +: PW]),
         .median  (med_rgb[(2-k)*PW +: PW])
      );
   end

   // ---------------- results ----------------
   mf33_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s2_valid_ff),
      .in_info       (s2_info_ff),
      .med_rgb       (med_rgb),
      .take          (merge_take),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_last  (rsp_out_last)
   );

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      CWC'(col_ff) < eff_w)
      else $error("column counter outside the frame width");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      RWC'(row_ff) < eff_h)
      else $error("row counter outside the frame height");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && s2_valid_ff)
      else $error("input stalled while the pipeline has room");

endmodule
